>>> design/bpe_pkg.sv
package bpe_pkg;

  localparam int unsigned ENVELOPE_DEPTH = 64;
  localparam int unsigned QUEUE_DEPTH    = 4;

  localparam int unsigned AMP_W   = 16;
  localparam int unsigned PRESS_W = 15;
  localparam int unsigned CV_W    = 9;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned USED_W  = 7;
  localparam int unsigned ENTRY_W = AMP_W + PRESS_W;

  localparam logic [PRESS_W-1:0] PRESSURE_LIMIT = 15'd50;
  localparam logic [PRESS_W-1:0] PRESSURE_MAX   = 15'd32767;
  localparam logic [PRESS_W-1:0] NO_MATCH_PRESS = 15'd1;

  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd1000;
  localparam logic [CFG_W-1:0] GAIN_RST      = 16'd256;
  localparam logic [CFG_W-1:0] OFFSET_RST    = 16'd0;
  localparam logic [CFG_W-1:0] SYS_RATIO_RST = 16'd36045;
  localparam logic [CFG_W-1:0] DIA_RATIO_RST = 16'd52429;
  localparam logic [CFG_W-1:0] WINDOW_RST    = 16'd500;

  typedef enum logic [2:0] {
    CFG_BEAT_THRESHOLD  = 3'd0,
    CFG_PRESSURE_GAIN   = 3'd1,
    CFG_PRESSURE_OFFSET = 3'd2,
    CFG_SYSTOLIC_RATIO  = 3'd3,
    CFG_DIASTOLIC_RATIO = 3'd4,
    CFG_MATCH_WINDOW    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]        beat_threshold;
    logic [CFG_W-1:0]        pressure_gain;
    logic signed [CFG_W-1:0] pressure_offset;
    logic [CFG_W-1:0]        systolic_ratio;
    logic [CFG_W-1:0]        diastolic_ratio;
    logic [CFG_W-1:0]        match_window;
  } cfg_t;

  // one word from the classifier to the envelope engine
  typedef struct packed {
    logic               append;
    logic               last;
    logic               overflow;
    logic [AMP_W-1:0]   amp;
    logic [PRESS_W-1:0] press;
  } cmd_t;

  localparam int unsigned CMD_W = $bits(cmd_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_PEAK  = 3'd1,
    ST_CALC  = 3'd2,
    ST_BOUND = 3'd3,
    ST_MATCH = 3'd4
  } back_state_e;

endpackage

>>> design/oscillometric_bp_estimator.sv
// Oscillometric blood pressure estimator.
// Input channel (in_valid_i / in_stall_o): one paired sample per word, a pulse
// amplitude and a cuff voltage in centivolts. Samples are taken one per cycle
// while in_stall_o is low; a classifier finds beats, tracks cuff pressure and
// posts envelope writes and end-of-measurement marks into a four-word queue.
// in_stall_o rises only while that queue is full.
// The envelope engine owns the store (one RAM of EnvelopeDepth entries). An
// end of measurement with N stored beats runs a peak scan and a window-match
// scan over the RAM read port, then loads a result into the output register.
// Output channel (out_valid_o / out_stall_i): one result word per measurement.
// The output register holds its word while the receiver stalls; the engine
// keeps draining envelope writes behind it and only waits at the next end.
// Configuration (cfg_valid_i / cfg_ready_o): always ready, index and 16 bit
// data, to be written by the user only while the block is idle; the block leaves this unenforced.
// Reset: asynchronous, clears the beat tracker, counts, queue and output
// valid, and loads the register defaults. The envelope RAM is not cleared:
// only entries written since the last measurement are ever read.
module oscillometric_bp_estimator import bpe_pkg::*; #(
  parameter int unsigned EnvelopeDepth = ENVELOPE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [AMP_W-1:0]   amplitude_sample_i,
  input  logic [CV_W-1:0]    pressure_centivolts_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PRESS_W-1:0] mean_pressure_o,
  output logic [PRESS_W-1:0] systolic_pressure_o,
  output logic [PRESS_W-1:0] diastolic_pressure_o,
  output logic [USED_W-1:0]  beats_used_o,
  output logic               beats_dropped_o
);

  cfg_t             cfg_q;
  cmd_t             push_cmd, pop_cmd;
  logic             push, pop, q_empty, q_full;
  logic [CMD_W-1:0] pop_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beat_threshold  <= THRESHOLD_RST;
      cfg_q.pressure_gain   <= GAIN_RST;
      cfg_q.pressure_offset <= OFFSET_RST;
      cfg_q.systolic_ratio  <= SYS_RATIO_RST;
      cfg_q.diastolic_ratio <= DIA_RATIO_RST;
      cfg_q.match_window    <= WINDOW_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_BEAT_THRESHOLD:  cfg_q.beat_threshold  <= cfg_data_i;
        CFG_PRESSURE_GAIN:   cfg_q.pressure_gain   <= cfg_data_i;
        CFG_PRESSURE_OFFSET: cfg_q.pressure_offset <= cfg_data_i;
        CFG_SYSTOLIC_RATIO:  cfg_q.systolic_ratio  <= cfg_data_i;
        CFG_DIASTOLIC_RATIO: cfg_q.diastolic_ratio <= cfg_data_i;
        CFG_MATCH_WINDOW:    cfg_q.match_window    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpe_front #(
    .EnvelopeDepth(EnvelopeDepth)
  ) u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_i                 (cfg_q),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .amplitude_sample_i    (amplitude_sample_i),
    .pressure_centivolts_i (pressure_centivolts_i),
    .push_o                (push),
    .cmd_o                 (push_cmd),
    .queue_full_i          (q_full)
  );

  bpe_fifo #(
    .Width(CMD_W),
    .Depth(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_cmd),
    .pop_i   (pop),
    .rdata_o (pop_word),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  assign pop_cmd = cmd_t'(pop_word);

  bpe_back #(
    .EnvelopeDepth(EnvelopeDepth)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .cmd_i                (pop_cmd),
    .queue_empty_i        (q_empty),
    .pop_o                (pop),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .mean_pressure_o      (mean_pressure_o),
    .systolic_pressure_o  (systolic_pressure_o),
    .diastolic_pressure_o (diastolic_pressure_o),
    .beats_used_o         (beats_used_o),
    .beats_dropped_o      (beats_dropped_o)
  );

endmodule

>>> design/bpe_ram.sv
module bpe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bpe_fifo.sv
module bpe_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

>>> design/bpe_front.sv
module bpe_front import bpe_pkg::*; #(
  parameter int unsigned EnvelopeDepth = ENVELOPE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [AMP_W-1:0]   amplitude_sample_i,
  input  logic [CV_W-1:0]    pressure_centivolts_i,
  output logic               push_o,
  output cmd_t               cmd_o,
  input  logic               queue_full_i
);

  localparam int unsigned CntW = $clog2(EnvelopeDepth + 1);
  localparam int unsigned ProdW = CV_W + CFG_W;
  localparam int unsigned SumW = ProdW + 2;

  logic [AMP_W-1:0]   prev_q, prev_d;
  logic               open_q, open_d;
  logic [AMP_W-1:0]   peak_a_q, peak_a_d;
  logic [PRESS_W-1:0] peak_p_q, peak_p_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               ovf_q, ovf_d;

  logic [ProdW-1:0]       prod;
  logic signed [SumW-1:0] sum;
  logic [SumW-9:0]        scaled;
  logic [PRESS_W-1:0]     press;
  logic [AMP_W-1:0]       amp;
  logic                   accept, append, last;

  assign in_stall_o = queue_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Q8.8 pressure, floored then clamped to the 15 bit range
  always_comb begin
    prod   = ProdW'(pressure_centivolts_i) * ProdW'(cfg_i.pressure_gain);
    sum    = $signed({2'b00, prod}) + SumW'(cfg_i.pressure_offset);
    scaled = sum[SumW-1:8];
    if (sum[SumW-1]) begin
      press = '0;
    end else if (scaled > (SumW-8)'(PRESSURE_MAX)) begin
      press = PRESSURE_MAX;
    end else begin
      press = scaled[PRESS_W-1:0];
    end
  end

  always_comb begin
    prev_d   = prev_q;
    open_d   = open_q;
    peak_a_d = peak_a_q;
    peak_p_d = peak_p_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    amp      = '0;
    append   = 1'b0;
    last     = 1'b0;

    // a beat amplitude shows up only on a falling edge
    if (amplitude_sample_i < prev_q) begin
      amp    = prev_q;
      prev_d = '0;
    end else begin
      prev_d = amplitude_sample_i;
    end

    if (amp > cfg_i.beat_threshold) begin
      if (press > PRESSURE_LIMIT) begin
        if (!open_q || amp > peak_a_q) begin
          peak_a_d = amp;
          peak_p_d = press;
        end
        open_d = 1'b1;
      end
    end else if (open_q) begin
      if (cnt_q != CntW'(EnvelopeDepth)) begin
        append = 1'b1;
        cnt_d  = cnt_q + 1'b1;
      end else begin
        ovf_d = 1'b1;
      end
      open_d   = 1'b0;
      peak_a_d = '0;
      peak_p_d = '0;
    end

    if (cnt_d != '0 && press < PRESSURE_LIMIT) begin
      last = 1'b1;
    end

    cmd_o.append   = append;
    cmd_o.last     = last;
    cmd_o.overflow = ovf_d;
    cmd_o.amp      = peak_a_q;
    cmd_o.press    = peak_p_q;

    if (last) begin
      cnt_d = '0;
      ovf_d = 1'b0;
    end
  end

  assign push_o = accept && (append || last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= '0;
      open_q   <= 1'b0;
      peak_a_q <= '0;
      peak_p_q <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (accept) begin
      prev_q   <= prev_d;
      open_q   <= open_d;
      peak_a_q <= peak_a_d;
      peak_p_q <= peak_p_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

>>> design/bpe_back.sv
module bpe_back import bpe_pkg::*; #(
  parameter int unsigned EnvelopeDepth = ENVELOPE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  input  logic               queue_empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PRESS_W-1:0] mean_pressure_o,
  output logic [PRESS_W-1:0] systolic_pressure_o,
  output logic [PRESS_W-1:0] diastolic_pressure_o,
  output logic [USED_W-1:0]  beats_used_o,
  output logic               beats_dropped_o
);

  localparam int unsigned AddrW = $clog2(EnvelopeDepth);
  localparam int unsigned CntW  = $clog2(EnvelopeDepth + 1);
  localparam int unsigned ProdW = AMP_W + CFG_W;

  back_state_e state_q, state_d;

  logic [CntW-1:0]    wcnt_q, wcnt_d;
  logic [CntW-1:0]    scan_cnt_q;
  logic               scan_ovf_q;
  logic [CntW-1:0]    rd_idx_q;
  logic               rvalid_q;
  logic [AMP_W-1:0]   peak_a_q;
  logic [PRESS_W-1:0] peak_p_q;
  logic [ProdW-1:0]   prod_s_q, prod_d_q;
  logic [AMP_W-1:0]   lo_s_q, lo_d_q;
  logic [AMP_W:0]     hi_s_q, hi_d_q;
  logic [PRESS_W-1:0] sys_q, dia_q;

  logic               out_valid_q;
  logic [PRESS_W-1:0] mean_q, sys_out_q, dia_out_q;
  logic [USED_W-1:0]  used_q;
  logic               dropped_q;

  logic               issue, scan_done, out_free, load_out, start_scan, start_match;
  logic [ENTRY_W-1:0] rdata;
  logic [AMP_W-1:0]   r_amp;
  logic [PRESS_W-1:0] r_press;
  logic [ProdW-1:0]   win;
  logic [ProdW:0]     hi_sum_s, hi_sum_d;

  assign r_amp     = rdata[ENTRY_W-1:PRESS_W];
  assign r_press   = rdata[PRESS_W-1:0];
  assign scan_done = (rd_idx_q == scan_cnt_q) && !rvalid_q;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign win       = {cfg_i.match_window, 16'b0};
  assign hi_sum_s  = {1'b0, prod_s_q} + {1'b0, win};
  assign hi_sum_d  = {1'b0, prod_d_q} + {1'b0, win};

  always_comb begin
    wcnt_d = wcnt_q;
    if (pop_o && cmd_i.append) begin
      wcnt_d = wcnt_q + 1'b1;
    end
  end

  bpe_ram #(
    .Width(ENTRY_W),
    .Depth(EnvelopeDepth)
  ) u_env_ram (
    .clk_i   (clk_i),
    .we_i    (pop_o && cmd_i.append),
    .waddr_i (wcnt_q[AddrW-1:0]),
    .wdata_i ({cmd_i.amp, cmd_i.press}),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!queue_empty_i && cmd_i.last) begin
          state_d = ST_PEAK;
        end
      end
      ST_PEAK: begin
        if (scan_done) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC:  state_d = ST_BOUND;
      ST_BOUND: state_d = ST_MATCH;
      ST_MATCH: begin
        if (scan_done && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o       = 1'b0;
    issue       = 1'b0;
    load_out    = 1'b0;
    start_scan  = 1'b0;
    start_match = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o      = !queue_empty_i;
        start_scan = !queue_empty_i && cmd_i.last;
      end
      ST_PEAK:  issue = (rd_idx_q != scan_cnt_q);
      ST_CALC:  ;
      ST_BOUND: start_match = 1'b1;
      ST_MATCH: begin
        issue    = (rd_idx_q != scan_cnt_q);
        load_out = scan_done && out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wcnt_q      <= '0;
      rd_idx_q    <= '0;
      rvalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= issue;
      if (start_scan) begin
        wcnt_q <= '0;
      end else begin
        wcnt_q <= wcnt_d;
      end
      if (start_scan || start_match) begin
        rd_idx_q <= '0;
      end else if (issue) begin
        rd_idx_q <= rd_idx_q + 1'b1;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_scan) begin
      scan_cnt_q <= wcnt_d;
      scan_ovf_q <= cmd_i.overflow;
      peak_a_q   <= '0;
      peak_p_q   <= '0;
      sys_q      <= NO_MATCH_PRESS;
      dia_q      <= NO_MATCH_PRESS;
    end
    // first entry with the largest amplitude wins
    if (state_q == ST_PEAK && rvalid_q && r_amp > peak_a_q) begin
      peak_a_q <= r_amp;
      peak_p_q <= r_press;
    end
    if (state_q == ST_CALC) begin
      prod_s_q <= ProdW'(peak_a_q) * ProdW'(cfg_i.systolic_ratio);
      prod_d_q <= ProdW'(peak_a_q) * ProdW'(cfg_i.diastolic_ratio);
    end
    if (state_q == ST_BOUND) begin
      lo_s_q <= (prod_s_q >= win) ? AMP_W'((prod_s_q - win) >> 16) : '0;
      lo_d_q <= (prod_d_q >= win) ? AMP_W'((prod_d_q - win) >> 16) : '0;
      hi_s_q <= hi_sum_s[ProdW:16];
      hi_d_q <= hi_sum_d[ProdW:16];
    end
    // last entry inside each window wins
    if (state_q == ST_MATCH && rvalid_q) begin
      if (r_amp > lo_s_q && {1'b0, r_amp} < hi_s_q) begin
        sys_q <= r_press;
      end
      if (r_amp > lo_d_q && {1'b0, r_amp} < hi_d_q) begin
        dia_q <= r_press;
      end
    end
    if (load_out) begin
      mean_q    <= peak_p_q;
      sys_out_q <= sys_q;
      dia_out_q <= dia_q;
      used_q    <= USED_W'(scan_cnt_q);
      dropped_q <= scan_ovf_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign mean_pressure_o      = mean_q;
  assign systolic_pressure_o  = sys_out_q;
  assign diastolic_pressure_o = dia_out_q;
  assign beats_used_o         = used_q;
  assign beats_dropped_o      = dropped_q;

endmodule

>>> design/bpe_checker.sv
module bpe_checker import bpe_pkg::*; #(
  parameter int unsigned EnvelopeDepth = ENVELOPE_DEPTH
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic [2:0]         cfg_index_i,
  input logic [CFG_W-1:0]   cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [AMP_W-1:0]   amplitude_sample_i,
  input logic [CV_W-1:0]    pressure_centivolts_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PRESS_W-1:0] mean_pressure_o,
  input logic [PRESS_W-1:0] systolic_pressure_o,
  input logic [PRESS_W-1:0] diastolic_pressure_o,
  input logic [USED_W-1:0]  beats_used_o,
  input logic               beats_dropped_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(mean_pressure_o)
      && $stable(systolic_pressure_o) && $stable(diastolic_pressure_o)
      && $stable(beats_used_o) && $stable(beats_dropped_o))
    else $error("result changed while stalled");

  // every stored beat was taken above the pressure limit
  a_mean_above_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mean_pressure_o > PRESSURE_LIMIT)
    else $error("mean pressure not above limit");

  a_used_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (EnvelopeDepth > 127) || (beats_used_o != '0
      && beats_used_o <= USED_W'(EnvelopeDepth)))
    else $error("beat count out of range");

  // beats are only dropped once the store is full
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beats_dropped_o |->
      (EnvelopeDepth > 127) || beats_used_o == USED_W'(EnvelopeDepth))
    else $error("drop flagged with store not full");

endmodule

bind oscillometric_bp_estimator bpe_checker #(
  .EnvelopeDepth(EnvelopeDepth)
) u_bpe_checker (.*);

>>> bench/bp_checker.sv
module bp_checker import bpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_o,
  input  logic [AMP_W-1:0]   amplitude_sample_i,
  input  logic [CV_W-1:0]    pressure_centivolts_i,
  input  logic               out_valid_o,
  input  logic               out_stall_i,
  input  logic [PRESS_W-1:0] mean_pressure_o,
  input  logic [PRESS_W-1:0] systolic_pressure_o,
  input  logic [PRESS_W-1:0] diastolic_pressure_o,
  input  logic [USED_W-1:0]  beats_used_o,
  input  logic               beats_dropped_o,
  output int unsigned        mismatches_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PRESS_W-1:0] mean_mmhg;
    logic [PRESS_W-1:0] systolic_mmhg;
    logic [PRESS_W-1:0] diastolic_mmhg;
    logic [USED_W-1:0]  beats_used;
    logic               beats_dropped;
  } reading_t;

  cfg_t               regs;
  logic [AMP_W-1:0]   last_sample;
  logic               beat_open;
  logic [AMP_W-1:0]   open_amp;
  logic [PRESS_W-1:0] open_press;
  logic [AMP_W-1:0]   env_amp [ENVELOPE_DEPTH];
  logic [PRESS_W-1:0] env_press [ENVELOPE_DEPTH];
  int unsigned        env_count;
  logic               env_dropped;
  reading_t           readings_due [$];
  reading_t           fresh;
  reading_t           got;
  reading_t           want;
  int unsigned        mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  // q8.8 gain times centivolts plus offset, floored and clamped
  function automatic logic [PRESS_W-1:0] cuff_mmhg(input logic [CV_W-1:0] cv);
    longint q88;
    q88 = longint'(cv) * longint'(regs.pressure_gain) + longint'($signed(regs.pressure_offset));
    if (q88 < 0) return '0;
    q88 = q88 >>> 8;
    if (q88 > longint'(PRESSURE_MAX)) return PRESSURE_MAX;
    return PRESS_W'(q88);
  endfunction

  // last stored beat strictly inside peak*ratio +/- window
  function automatic logic [PRESS_W-1:0] window_pick(input logic [AMP_W-1:0] peak,
                                                     input logic [CFG_W-1:0] ratio);
    longint unsigned prod;
    longint unsigned span;
    longint unsigned lo;
    longint unsigned hi;
    logic [PRESS_W-1:0] pick;
    prod = 64'(peak) * 64'(ratio);
    span = 64'(regs.match_window) << 16;
    lo = (prod >= span) ? (prod - span) >> 16 : 64'd0;
    hi = (prod + span) >> 16;
    pick = NO_MATCH_PRESS;
    for (int unsigned i = 0; i < env_count; i++) begin
      if (64'(env_amp[i]) > lo && 64'(env_amp[i]) < hi) pick = env_press[i];
    end
    return pick;
  endfunction

  function automatic bit absorb_sample(input logic [AMP_W-1:0] cur,
                                       input logic [CV_W-1:0] cv,
                                       output reading_t rd);
    logic [AMP_W-1:0]   beat;
    logic [PRESS_W-1:0] press;
    logic [AMP_W-1:0]   peak_amp;
    logic [PRESS_W-1:0] peak_press;
    rd = '0;
    beat = '0;
    press = cuff_mmhg(cv);
    // a beat shows up on the falling edge only, then the edge detector restarts from zero
    if (cur < last_sample) begin
      beat = last_sample;
      last_sample = '0;
    end else begin
      last_sample = cur;
    end
    if (beat > regs.beat_threshold) begin
      if (press > PRESSURE_LIMIT) begin
        if (!beat_open || beat > open_amp) begin
          open_amp = beat;
          open_press = press;
        end
        beat_open = 1'b1;
      end
    end else if (beat_open) begin
      if (env_count < ENVELOPE_DEPTH) begin
        env_amp[env_count] = open_amp;
        env_press[env_count] = open_press;
        env_count++;
      end else begin
        env_dropped = 1'b1;
      end
      beat_open = 1'b0;
      open_amp = '0;
      open_press = '0;
    end
    if (env_count == 0 || press >= PRESSURE_LIMIT) return 1'b0;
    peak_amp = '0;
    peak_press = '0;
    for (int unsigned i = 0; i < env_count; i++) begin
      if (env_amp[i] > peak_amp) begin
        peak_amp = env_amp[i];
        peak_press = env_press[i];
      end
    end
    rd.mean_mmhg = peak_press;
    rd.systolic_mmhg = window_pick(peak_amp, regs.systolic_ratio);
    rd.diastolic_mmhg = window_pick(peak_amp, regs.diastolic_ratio);
    rd.beats_used = USED_W'(env_count);
    rd.beats_dropped = env_dropped;
    env_count = 0;
    env_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.beat_threshold = THRESHOLD_RST;
      regs.pressure_gain = GAIN_RST;
      regs.pressure_offset = OFFSET_RST;
      regs.systolic_ratio = SYS_RATIO_RST;
      regs.diastolic_ratio = DIA_RATIO_RST;
      regs.match_window = WINDOW_RST;
      last_sample = '0;
      beat_open = 1'b0;
      open_amp = '0;
      open_press = '0;
      env_count = 0;
      env_dropped = 1'b0;
      readings_due.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got.mean_mmhg = mean_pressure_o;
        got.systolic_mmhg = systolic_pressure_o;
        got.diastolic_mmhg = diastolic_pressure_o;
        got.beats_used = beats_used_o;
        got.beats_dropped = beats_dropped_o;
        if (readings_due.size() == 0) begin
          $display("%0t: result word mismatch, expected none, actual %0d/%0d/%0d used %0d dropped %0d",
                   $time, got.mean_mmhg, got.systolic_mmhg, got.diastolic_mmhg,
                   got.beats_used, got.beats_dropped);
          mismatch_count++;
        end else begin
          want = readings_due.pop_front();
          check_field("mean_pressure", want.mean_mmhg, got.mean_mmhg);
          check_field("systolic_pressure", want.systolic_mmhg, got.systolic_mmhg);
          check_field("diastolic_pressure", want.diastolic_mmhg, got.diastolic_mmhg);
          check_field("beats_used", want.beats_used, got.beats_used);
          check_field("beats_dropped", want.beats_dropped, got.beats_dropped);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_BEAT_THRESHOLD:  regs.beat_threshold = cfg_data_i;
          CFG_PRESSURE_GAIN:   regs.pressure_gain = cfg_data_i;
          CFG_PRESSURE_OFFSET: regs.pressure_offset = cfg_data_i;
          CFG_SYSTOLIC_RATIO:  regs.systolic_ratio = cfg_data_i;
          CFG_DIASTOLIC_RATIO: regs.diastolic_ratio = cfg_data_i;
          CFG_MATCH_WINDOW:    regs.match_window = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        if (absorb_sample(amplitude_sample_i, pressure_centivolts_i, fresh)) begin
          readings_due = {readings_due, fresh};
        end
      end
    end
    pending_o <= readings_due.size();
  end

endmodule

>>> bench/testbench.sv
module testbench import bpe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SETTLE_CYCLES  = 200;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_mode_e;
  typedef enum {
    PH_DEFAULT, PH_EDGE_LOW, PH_EDGE_HIGH, PH_WIDE_WINDOW, PH_RANDOM, PH_RESTORE
  } setting_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [CFG_W-1:0]   cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [AMP_W-1:0]   amplitude_sample_i = '0;
  logic [CV_W-1:0]    pressure_centivolts_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [PRESS_W-1:0] mean_pressure_o;
  logic [PRESS_W-1:0] systolic_pressure_o;
  logic [PRESS_W-1:0] diastolic_pressure_o;
  logic [USED_W-1:0]  beats_used_o;
  logic               beats_dropped_o;

  int unsigned error_count;
  int unsigned readings_pending;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  stall_mode_e stall_mode = STALL_NONE;

  setting_e plan [10] = '{PH_DEFAULT, PH_EDGE_LOW, PH_EDGE_HIGH, PH_WIDE_WINDOW, PH_RANDOM,
                          PH_RANDOM, PH_RANDOM, PH_RANDOM, PH_RANDOM, PH_RESTORE};

  oscillometric_bp_estimator u_top (.*);

  bp_checker u_checker (.*, .mismatches_o(error_count), .pending_o(readings_pending));

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      stall_left <= $urandom_range(40, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      default:     out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_sample(input logic [AMP_W-1:0] amp, input logic [CV_W-1:0] cv);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400)
                                                : $urandom_range(1, 30);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    amplitude_sample_i <= amp;
    pressure_centivolts_i <= cv;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic program_register(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // hold the sender until every reading is in, then let queued envelope writes drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (readings_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int unsigned budget;
    int unsigned phase_start;
    int unsigned beats;
    int unsigned top_amp;
    int unsigned cv_hi;
    int unsigned cv_lo;
    int unsigned cv;
    int unsigned spread;
    int unsigned peak;
    int unsigned rise;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // full-scale beat at full-scale cuff voltage
    send_sample(16'd0, 9'd330);
    send_sample(16'd65535, 9'd330);
    send_sample(16'd0, 9'd330);
    send_sample(16'd0, 9'd200);
    // equal peak later on: the earlier entry must win
    send_sample(16'd65535, 9'd150);
    send_sample(16'd0, 9'd150);
    send_sample(16'd1, 9'd150);
    // beat exactly at threshold is ignored
    send_sample(16'd1000, 9'd120);
    send_sample(16'd0, 9'd120);
    // just over threshold, just over the pressure limit
    send_sample(16'd1001, 9'd51);
    send_sample(16'd0, 9'd51);
    send_sample(16'd2, 9'd50);
    // beat at exactly the pressure limit is neither grouped nor an end
    send_sample(16'd3000, 9'd50);
    send_sample(16'd0, 9'd50);
    // systolic window hit, then group close and end on the same word
    send_sample(16'd36044, 9'd200);
    send_sample(16'd0, 9'd200);
    send_sample(16'd5, 9'd10);
    // beat at zero pressure with an empty store
    send_sample(16'd4000, 9'd0);
    send_sample(16'd0, 9'd0);
    send_sample(16'd65535, 9'd255);
    send_sample(16'd0, 9'd256);
    send_sample(16'd7, 9'd40);

    foreach (plan[p]) begin
      if (plan[p] != PH_DEFAULT) begin
        wait_idle();
        case (plan[p])
          PH_EDGE_LOW: begin
            program_register(CFG_BEAT_THRESHOLD, 16'd0);
            program_register(CFG_PRESSURE_GAIN, 16'hffff);
            program_register(CFG_PRESSURE_OFFSET, 16'h8000);
            program_register(CFG_SYSTOLIC_RATIO, 16'd0);
            program_register(CFG_DIASTOLIC_RATIO, 16'hffff);
            program_register(CFG_MATCH_WINDOW, 16'd0);
          end
          PH_EDGE_HIGH: begin
            program_register(CFG_BEAT_THRESHOLD, 16'hffff);
            program_register(CFG_PRESSURE_GAIN, 16'd0);
            program_register(CFG_PRESSURE_OFFSET, 16'h7fff);
            program_register(CFG_SYSTOLIC_RATIO, 16'hffff);
            program_register(CFG_DIASTOLIC_RATIO, 16'd0);
            program_register(CFG_MATCH_WINDOW, 16'hffff);
          end
          PH_WIDE_WINDOW: begin
            program_register(CFG_BEAT_THRESHOLD, THRESHOLD_RST);
            program_register(CFG_PRESSURE_GAIN, GAIN_RST);
            program_register(CFG_PRESSURE_OFFSET, OFFSET_RST);
          end
          PH_RESTORE: begin
            program_register(CFG_BEAT_THRESHOLD, THRESHOLD_RST);
            program_register(CFG_PRESSURE_GAIN, GAIN_RST);
            program_register(CFG_PRESSURE_OFFSET, OFFSET_RST);
            program_register(CFG_SYSTOLIC_RATIO, SYS_RATIO_RST);
            program_register(CFG_DIASTOLIC_RATIO, DIA_RATIO_RST);
            program_register(CFG_MATCH_WINDOW, WINDOW_RST);
          end
          default: begin
            program_register(CFG_BEAT_THRESHOLD, CFG_W'($urandom_range(0, 4000)));
            program_register(CFG_PRESSURE_GAIN, CFG_W'($urandom_range(100, 600)));
            program_register(CFG_PRESSURE_OFFSET,
                             CFG_W'($urandom_range(0, 6000) - 3000));
            program_register(CFG_SYSTOLIC_RATIO, CFG_W'($urandom_range(0, 65535)));
            program_register(CFG_DIASTOLIC_RATIO, CFG_W'($urandom_range(0, 65535)));
            program_register(CFG_MATCH_WINDOW, CFG_W'(($urandom_range(0, 3) == 0) ?
                             $urandom_range(0, 20000) : $urandom_range(0, 3000)));
          end
        endcase
        cfg_valid_i <= 1'b0;
      end

      budget = (plan[p] == PH_EDGE_HIGH) ? 40 : 165;
      phase_start = items_sent;
      while (items_sent - phase_start < budget) begin
        if ($urandom_range(0, 6) == 0) begin
          repeat ($urandom_range(1, 10)) send_sample(AMP_W'($urandom_range(0, 65535)),
                                                     CV_W'($urandom_range(0, 330)));
        end else begin
          // one deflation: bell-shaped beat peaks over falling cuff voltage
          beats = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 30);
          top_amp = $urandom_range(1500, 65535);
          cv_hi = $urandom_range(120, 330);
          cv_lo = cv_hi / 3;
          for (int unsigned b = 0; b < beats; b++) begin
            spread = (2 * b > beats) ? 2 * b - beats : beats - 2 * b;
            peak = top_amp * (beats + 1 - spread) / (beats + 1) + $urandom_range(0, 600);
            if (peak > 65535) peak = 65535;
            cv = cv_hi - (cv_hi - cv_lo) * b / beats;
            rise = $urandom_range(1, 3);
            for (int unsigned r = 1; r <= rise; r++) begin
              send_sample(AMP_W'(peak * r / rise), CV_W'(cv));
            end
            send_sample(AMP_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, peak - 1) : 0),
                        CV_W'(cv));
            if ($urandom_range(0, 40) == 0) begin
              send_sample(AMP_W'($urandom_range(0, 65535)), CV_W'($urandom_range(0, 330)));
            end
          end
          cv = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : 0;
          repeat ($urandom_range(1, 3)) send_sample(AMP_W'($urandom_range(0, 200)), CV_W'(cv));
        end
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
